// ----- design/lsup_pkg.sv -----
// ----------------------------------------------------------------------------
// lsup_pkg
// Shared types and constants of the unique-push LIFO stack.
// ----------------------------------------------------------------------------
package lsup_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 31;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NEG   = 3'd1,
        ST_DUP   = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   result_value;
    } out_word_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic       valid;
        out_word_t  word;
    } res_t;

    // Memory access request issued by the sequencer.
    typedef struct packed {
        logic               re;
        logic [ADDR_W-1:0]  raddr;
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VAL_W-1:0]   wdata;
    } mem_req_t;

endpackage

// ----- design/lsup_ram.sv -----
// ----------------------------------------------------------------------------
// lsup_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsup_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 31,
    parameter int ADDR_P  = 4
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_P-1:0]  waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_P-1:0]  raddr,
    output logic [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lsup_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsup_ctrl
// Command sequencer: duplicate scan, push/pop and stack count.
// ----------------------------------------------------------------------------
module lsup_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lsup_pkg::in_word_t     s_word,
    input  logic [lsup_pkg::VAL_W-1:0] rdata,
    output lsup_pkg::mem_req_t     mem_req,
    input  logic                   out_free,
    output lsup_pkg::res_t         res
);
    import lsup_pkg::*;

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    out_word_t          res_reg, res_next;
    logic [CNT_W-1:0]   idx_plus1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        res_next   = res_reg;
        mem_req    = '0;
        s_ready    = 1'b0;
        res.valid  = 1'b0;
        res.word   = res_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    val_next = s_word.value[VAL_W-1:0];
                    if (s_word.cmd == CMD_POP) begin
                        if (count_reg == '0) begin
                            res_next   = '{status: ST_EMPTY, result_value: '0};
                            state_next = S_DONE;
                        end else begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                            state_next    = S_POP;
                        end
                    end else if (s_word.value[31]) begin
                        res_next   = '{status: ST_NEG, result_value: '0};
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        // nothing to compare against: write straight away
                        mem_req.we    = 1'b1;
                        mem_req.waddr = '0;
                        mem_req.wdata = s_word.value[VAL_W-1:0];
                        count_next    = CNT_W'(1);
                        res_next      = '{status: ST_OK,
                                          result_value: s_word.value[VAL_W-1:0]};
                        state_next    = S_DONE;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = '0;
                        idx_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_POP: begin
                count_next = count_reg - CNT_W'(1);
                res_next   = '{status: ST_OK, result_value: rdata};
                state_next = S_DONE;
            end
            S_SCAN: begin
                // rdata holds the entry at idx_reg
                if (rdata == val_reg) begin
                    res_next   = '{status: ST_DUP, result_value: '0};
                    state_next = S_DONE;
                end else if (idx_plus1 == count_reg) begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        res_next = '{status: ST_FULL, result_value: '0};
                    end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_reg[ADDR_W-1:0];
                        mem_req.wdata = val_reg;
                        count_next    = count_reg + CNT_W'(1);
                        res_next      = '{status: ST_OK,
                                          result_value: val_reg};
                    end
                    state_next = S_DONE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_plus1[ADDR_W-1:0];
                    idx_next      = idx_plus1[ADDR_W-1:0];
                end
            end
            S_DONE: begin
                res.valid = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/lifo_stack_unique_push.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_unique_push
// LIFO stack of non-negative 31-bit values that refuses duplicate pushes.
// ----------------------------------------------------------------------------
// Each input word is a push or a pop and yields exactly one result word with
// a status (ok, negative, duplicate, full, empty) and a value. Entries live
// in a single synchronous RAM with a registered read port. A push walks the
// occupied entries one RAM read per cycle to look for a duplicate. One
// command is in flight at a time. Results sit in an output register, so the
// next command is taken while a result still waits. Stored entries need no
// reset; the stack count clears on reset.
// ----------------------------------------------------------------------------
module lifo_stack_unique_push (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lsup_pkg::in_word_t   s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lsup_pkg::out_word_t  m_word
);
    import lsup_pkg::*;

    mem_req_t          mem_req;
    res_t              res;
    logic [VAL_W-1:0]  rdata;
    logic              out_free;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_word_reg, m_word_next;

    // Entry store.
    lsup_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (VAL_W),
        .ADDR_P  (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // Sequencer: scan, push, pop, count.
    lsup_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .rdata    (rdata),
        .mem_req  (mem_req),
        .out_free (out_free),
        .res      (res)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (res.valid) begin
            // load the finished result
            m_valid_next = 1'b1;
            m_word_next  = res.word;
        end else if (m_ready) begin
            // drop the delivered word
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");

    // No new command while a result is still being handed off.
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res.valid)
        else $error("input ready while a result is pending");

    // Refused commands carry a zero value.
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.status != ST_OK) |-> (m_word.result_value == '0))
        else $error("refused result with nonzero value");

    // The sequencer never reads and writes the store in the same cycle.
    a_mem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.re && mem_req.we))
        else $error("simultaneous store read and write");

endmodule

// ----- sim/stack_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// stack_tracker_pkg
// Predicts the unique-push LIFO stack and matches its result words in order.
// ----------------------------------------------------------------------------
package stack_tracker_pkg;

    import lsup_pkg::*;

    class stack_tracker;

        logic [VAL_W-1:0] entries [DEPTH];
        int unsigned      depth_used;
        out_word_t        pending_results [$];
        int unsigned      fail_count;

        function new();
            depth_used = 0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Return a value that is on the stack now, or a small one if it is empty.
        function logic [VAL_W-1:0] pick_held();
            if (depth_used == 0) begin
                return VAL_W'($urandom_range(31));
            end
            return entries[$urandom_range(depth_used - 1)];
        endfunction

        // Advance the stack copy by one accepted word and queue its result.
        function void note_command(in_word_t w);
            out_word_t        r;
            logic [VAL_W-1:0] v;
            bit               dup;
            int unsigned      i;
            r.status       = ST_OK;
            r.result_value = '0;
            if (w.cmd == CMD_PUSH) begin
                v   = w.value[VAL_W-1:0];
                dup = 1'b0;
                for (i = 0; i < depth_used; i++) begin
                    if (entries[i] == v) begin
                        dup = 1'b1;
                    end
                end
                if (w.value[31]) begin
                    r.status = ST_NEG;
                end else if (dup) begin
                    r.status = ST_DUP;
                end else if (depth_used >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    entries[depth_used] = v;
                    depth_used++;
                    r.result_value = v;
                end
            end else begin
                if (depth_used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    depth_used--;
                    r.result_value = entries[depth_used];
                end
            end
            pending_results.push_back(r);
        endfunction

        // Match one result word against the oldest queued one.
        function void check_result(out_word_t got);
            out_word_t want;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result word with nothing pending: status %0d value %0d",
                             $realtime, got.status, got.result_value);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.result_value !== want.result_value) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: status want %0d got %0d, value want %0d got %0d",
                             $realtime, want.status, got.status,
                             want.result_value, got.result_value);
                end
            end
        endfunction

    endclass

endpackage

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the unique-push LIFO stack.
// ----------------------------------------------------------------------------
// Drives push and pop words through the valid/ready input, predicts every
// result word with a stack copy in the tracker, and checks each result word
// in order. A short directed run covers empty pops, both value extremes,
// negative pushes, duplicates, a full stack and the check order on push.
// Random bursts then fill, drain and churn the stack with values drawn to hit
// duplicates often, under three idling profiles on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lsup_pkg::*;
    import stack_tracker_pkg::*;

    localparam int RANDOM_WORDS = 1300;
    localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 40;    // longer than the slowest push

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    stack_tracker tracker;

    // Percent of cycles in which each side holds off.
    int tx_idle_pct = 20;
    int rx_idle_pct = 48;

    int stall_cycles = 0;
    int burst_mode   = 0;
    int burst_left   = 0;

    lifo_stack_unique_push i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #6 aclk = ~aclk;

    // Throttle the result channel at random.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every result word taken at this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_word);
        end
    end

    // End the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[lifo_stack_unique_push] ERROR");
                $finish;
            end
        end
    end

    // Offer one word, hold it until taken, and note it in the tracker.
    // Call at a rising edge; return at the edge that accepted it, valid still high.
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.note_command(w);
    endtask

    task automatic send_push(logic signed [31:0] v);
        send_word(in_word_t'{cmd: CMD_PUSH, value: v});
    endtask

    task automatic send_pop(logic signed [31:0] v);
        send_word(in_word_t'{cmd: CMD_POP, value: v});
    endtask

    // Drop valid and hold until every queued result word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Build a random word. Fill bursts lean on push, drain bursts on pop.
    // Push values favor ones already held and a small pool, so duplicates
    // and a full stack come up often.
    function automatic in_word_t make_word(int mode);
        in_word_t w;
        int       push_pct;
        int       pick;
        push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
        w.value  = $urandom();
        if ($urandom_range(99) >= push_pct) begin
            w.cmd = CMD_POP;
            return w;
        end
        w.cmd = CMD_PUSH;
        pick  = $urandom_range(99);
        if (pick < 10) begin
            w.value[31] = 1'b1;
        end else if (pick < 35) begin
            w.value = {1'b0, tracker.pick_held()};
        end else if (pick < 70) begin
            w.value = $urandom_range(31);
        end else if (pick < 76) begin
            w.value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
        end else begin
            w.value[31] = 1'b0;
        end
        return w;
    endfunction

    initial begin
        int i;
        int phase;
        tracker = new();

        // Hold reset at the start, then release once for the whole run.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pop, extremes, negatives, duplicates, full stack.
        send_pop(32'sh8000_0000);
        send_push(32'sh0);
        send_push(32'sh0);
        send_push(32'sh7FFF_FFFF);
        send_push(32'sh8000_0000);
        send_push(-32'sd1);
        send_push(32'sh7FFF_FFFF);
        send_pop(32'sh0);
        for (i = 1; i <= 15; i++) begin
            send_push(i);
        end
        // Stack is full here: a new value hits full, a held one is reported
        // as a duplicate first, and a negative value wins over both.
        send_push(32'sd1000);
        send_push(32'sd5);
        send_push(32'shC000_0000);
        send_pop(-32'sd1);

        // Random bursts under three idling profiles.
        for (phase = 0; phase < 3; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_WORDS / 3; i++) begin
                if (burst_left == 0) begin
                    burst_mode = $urandom_range(2);
                    burst_left = $urandom_range(8, 40);
                end
                burst_left--;
                // Now and then let the stack go fully quiet before the next word.
                if ($urandom_range(59) == 0) begin
                    drain_results();
                end
                send_word(make_word(burst_mode));
            end
        end

        // Wait out the last results, then a tail to catch stray words.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("[lifo_stack_unique_push] OK");
        end else begin
            $display("[lifo_stack_unique_push] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/lsup_pkg.sv
design/lsup_ram.sv
design/lsup_ctrl.sv
design/lifo_stack_unique_push.sv
sim/stack_tracker_pkg.sv
sim/tb_top.sv
